### sv/crsr_pkg.sv
// Shared constants, command codes and beat types for the card reader status responder.
package crsr_pkg;

  localparam int KEY_COUNT_DEF = 12;
  localparam int KEYS_W        = 12;
  localparam int UID_W         = 64;
  localparam int IDX_W         = 4;
  localparam int CNT_W         = 4;
  localparam int LEN_W         = 5;

  // Request command codes.
  localparam logic [7:0] CMD_INIT_A     = 8'h00;
  localparam logic [7:0] CMD_INIT_B     = 8'h03;
  localparam logic [7:0] CMD_INIT_C     = 8'h16;
  localparam logic [7:0] CMD_INIT_D     = 8'h20;
  localparam logic [7:0] CMD_INIT_E     = 8'h30;
  localparam logic [7:0] CMD_CARD_READ  = 8'h31;
  localparam logic [7:0] CMD_STATUS     = 8'h34;
  localparam logic [7:0] CMD_SET_ACTION = 8'h35;
  localparam logic [7:0] CMD_NEW_READ   = 8'h61;

  // Set-action arguments.
  localparam logic [7:0] ACT_STOP   = 8'h00;
  localparam logic [7:0] ACT_ACCEPT = 8'h11;
  localparam logic [7:0] ACT_EJECT  = 8'h12;

  localparam logic [7:0] PRESENCE_CARD = 8'h02;
  localparam logic [7:0] PRESENCE_NONE = 8'h04;
  localparam logic [7:0] SENSOR_NONE   = 8'h00;
  localparam logic [7:0] SENSOR_FRONT  = 8'h10;
  localparam logic [7:0] SENSOR_BOTH   = 8'h30;
  localparam logic [7:0] REPLY_ZERO    = 8'h00;
  localparam logic [7:0] REPLY_ACK     = 8'h01;

  localparam logic [LEN_W-1:0] LEN_NONE  = 5'd0;
  localparam logic [LEN_W-1:0] LEN_SHORT = 5'd1;
  localparam logic [LEN_W-1:0] LEN_FULL  = 5'd16;

  localparam logic [CNT_W-1:0] CNT_BASE = 4'h8;

  typedef struct packed {
    logic [7:0]        cmd;
    logic [7:0]        action;
    logic [KEYS_W-1:0] keys;
    logic              card_present;
    logic [UID_W-1:0]  card_uid;
  } req_t;

  typedef struct packed {
    logic [KEYS_W-1:0] prev_keys;
    logic [CNT_W-1:0]  press_cnt;
    logic              accepting;
    logic              holding;
    logic              new_mode;
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0]  data_length;
    logic [7:0]        reply_byte;
    logic [7:0]        presence_code;
    logic [7:0]        sensor_code;
    logic [7:0]        keydown_code;
    logic [KEYS_W-1:0] keys_out;
    logic [UID_W-1:0]  uid_out;
  } rsp_t;

  localparam state_t STATE_RESET = '{
    prev_keys: '0,
    press_cnt: CNT_BASE,
    accepting: 1'b0,
    holding:   1'b0,
    new_mode:  1'b0
  };

endpackage

### sv/crsr_core.sv
// Request decode, key scan and reply packing for one request beat.
module crsr_core #(
  parameter int KEY_COUNT = crsr_pkg::KEY_COUNT_DEF
) (
  input  crsr_pkg::req_t   req,
  input  crsr_pkg::state_t state,
  input  logic             reply_on_new_read,
  output crsr_pkg::rsp_t   rsp,
  output crsr_pkg::state_t state_nxt
);

  logic [crsr_pkg::KEYS_W-1:0] scan_mask;
  logic [crsr_pkg::KEYS_W-1:0] rising;
  logic [crsr_pkg::IDX_W-1:0]  key_idx;
  logic                        accepting_act;
  logic                        holding_act;

  always_comb begin
    for (int i = 0; i < crsr_pkg::KEYS_W; i++) begin
      scan_mask[i] = (i < KEY_COUNT);
    end
  end

  assign rising = ~state.prev_keys & req.keys & scan_mask;

  // Lowest set bit wins, so walk from the top down.
  always_comb begin
    key_idx = '0;
    for (int i = crsr_pkg::KEYS_W - 1; i >= 0; i--) begin
      if (rising[i]) begin
        key_idx = crsr_pkg::IDX_W'(i);
      end
    end
  end

  // Flags after the set-action argument is applied.
  always_comb begin
    accepting_act = state.accepting;
    holding_act   = state.holding;
    if (req.cmd == crsr_pkg::CMD_SET_ACTION) begin
      case (req.action)
        crsr_pkg::ACT_STOP:   accepting_act = 1'b0;
        crsr_pkg::ACT_ACCEPT: accepting_act = 1'b1;
        crsr_pkg::ACT_EJECT: begin
          accepting_act = 1'b0;
          holding_act   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rsp       = '0;
    state_nxt = state;
    case (req.cmd)
      crsr_pkg::CMD_INIT_A, crsr_pkg::CMD_INIT_B, crsr_pkg::CMD_INIT_C,
      crsr_pkg::CMD_INIT_D, crsr_pkg::CMD_INIT_E: begin
        rsp.data_length = crsr_pkg::LEN_SHORT;
        rsp.reply_byte  = crsr_pkg::REPLY_ZERO;
      end
      crsr_pkg::CMD_CARD_READ: begin
        rsp.data_length = crsr_pkg::LEN_FULL;
        rsp.reply_byte  = crsr_pkg::REPLY_ACK;
        rsp.sensor_code = req.card_present ? crsr_pkg::SENSOR_FRONT : crsr_pkg::SENSOR_NONE;
      end
      crsr_pkg::CMD_STATUS, crsr_pkg::CMD_SET_ACTION: begin
        state_nxt.accepting = accepting_act;
        state_nxt.holding   = holding_act;
        rsp.data_length     = crsr_pkg::LEN_FULL;
        rsp.reply_byte      = crsr_pkg::REPLY_ZERO;
        if (|rising) begin
          rsp.keydown_code    = {state.press_cnt, key_idx};
          // The counter stays within 8..15: wrap the low three bits only.
          state_nxt.press_cnt = {1'b1, state.press_cnt[2:0] + 3'd1};
        end
        state_nxt.prev_keys = req.keys;
        if (state.new_mode) begin
          rsp.presence_code = req.card_present ? crsr_pkg::PRESENCE_CARD
                                               : crsr_pkg::PRESENCE_NONE;
          rsp.sensor_code   = crsr_pkg::SENSOR_NONE;
        end else begin
          state_nxt.holding = holding_act | (accepting_act & req.card_present);
          if (state_nxt.holding) begin
            rsp.presence_code = crsr_pkg::PRESENCE_CARD;
            rsp.sensor_code   = crsr_pkg::SENSOR_BOTH;
          end else if (req.card_present) begin
            rsp.presence_code = crsr_pkg::PRESENCE_CARD;
            rsp.sensor_code   = crsr_pkg::SENSOR_FRONT;
          end else begin
            rsp.presence_code = crsr_pkg::PRESENCE_NONE;
            rsp.sensor_code   = crsr_pkg::SENSOR_NONE;
          end
        end
        rsp.keys_out = req.keys;
        rsp.uid_out  = req.card_present ? req.card_uid : '0;
      end
      crsr_pkg::CMD_NEW_READ: begin
        state_nxt.new_mode = 1'b1;
        if (reply_on_new_read) begin
          rsp.data_length = crsr_pkg::LEN_SHORT;
          rsp.reply_byte  = crsr_pkg::REPLY_ACK;
        end
      end
      default: ;
    endcase
  end

endmodule

### sv/card_reader_status_responder.sv
// Top level of the card reader status responder: request register, reply register, state.
// Each request beat yields exactly one reply beat. A beat is captured in the request
// register, decoded by one level of shallow logic and written to the reply register, so
// the block takes one beat per clock cycle as long as out_ready does not stall it, and a
// reply is presented on the outputs from the reply register. The reader state (keypad
// history, press counter, accept/hold/mode flags) is updated in the same cycle the request
// moves into the reply register, so the next request always sees it. The configuration
// register is written through its own channel, which is always ready; write it only while
// no request is in flight.
module card_reader_status_responder #(
  parameter int KEY_COUNT = crsr_pkg::KEY_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_cmd,
  input  logic [7:0]                    in_action,
  input  logic [crsr_pkg::KEYS_W-1:0]   in_keys,
  input  logic                          in_card_present,
  input  logic [crsr_pkg::UID_W-1:0]    in_card_uid,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [crsr_pkg::LEN_W-1:0]    out_data_length,
  output logic [7:0]                    out_reply_byte,
  output logic [7:0]                    out_presence_code,
  output logic [7:0]                    out_sensor_code,
  output logic [7:0]                    out_keydown_code,
  output logic [crsr_pkg::KEYS_W-1:0]   out_keys_out,
  output logic [crsr_pkg::UID_W-1:0]    out_uid_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data
);

  logic             req_valid_r;
  crsr_pkg::req_t   req_r;
  logic             out_valid_r;
  crsr_pkg::rsp_t   rsp_r;
  crsr_pkg::rsp_t   rsp_nxt;
  crsr_pkg::state_t state_r;
  crsr_pkg::state_t state_nxt;
  logic             reply_on_new_read_r;
  logic             out_load;
  logic             req_load;

  assign out_load  = req_valid_r && (!out_valid_r || out_ready);
  assign req_load  = in_valid && in_ready;
  assign in_ready  = !req_valid_r || out_load;
  assign cfg_ready = 1'b1;

  crsr_core #(
    .KEY_COUNT(KEY_COUNT)
  ) u_core (
    .req               (req_r),
    .state             (state_r),
    .reply_on_new_read (reply_on_new_read_r),
    .rsp               (rsp_nxt),
    .state_nxt         (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r         <= 1'b0;
      out_valid_r         <= 1'b0;
      state_r             <= crsr_pkg::STATE_RESET;
      reply_on_new_read_r <= 1'b0;
    end else begin
      if (req_load) begin
        req_valid_r <= 1'b1;
      end else if (out_load) begin
        req_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        reply_on_new_read_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_load) begin
      req_r <= '{
        cmd:          in_cmd,
        action:       in_action,
        keys:         in_keys,
        card_present: in_card_present,
        card_uid:     in_card_uid
      };
    end
    if (out_load) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data_length   = rsp_r.data_length;
  assign out_reply_byte    = rsp_r.reply_byte;
  assign out_presence_code = rsp_r.presence_code;
  assign out_sensor_code   = rsp_r.sensor_code;
  assign out_keydown_code  = rsp_r.keydown_code;
  assign out_keys_out      = rsp_r.keys_out;
  assign out_uid_out       = rsp_r.uid_out;

  // The press counter never leaves the range 8 to 15.
  assert property (@(posedge clk) disable iff (!rst_n) state_r.press_cnt[3])
    else $error("press counter left its range");

  // A key-down code only rides on a full status reply.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (rsp_r.keydown_code != 8'h00) |-> rsp_r.data_length == crsr_pkg::LEN_FULL)
    else $error("key-down code on a reply that is not a status reply");

  // A nonzero UID is reported only together with a present card.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (rsp_r.uid_out != '0) |-> rsp_r.presence_code == crsr_pkg::PRESENCE_CARD)
    else $error("UID reported without card presence");

  // Holding is only ever set by a status or set-action beat in the old mode.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r.holding) |-> $past(out_load) && !$past(state_r.new_mode))
    else $error("hold flag set outside an old-mode status beat");

endmodule

### test/tb.sv
// Self-checking testbench for the card reader status responder: directed table, random beats, predictor.
module tb;

  localparam int CYCLE_LIMIT    = 100000;
  localparam int PLAN_ROWS      = 25;
  localparam int SQUEEZE_CYCLES = 80;

  localparam logic [7:0] CMD_UNKNOWN_HI = 8'hFF;
  localparam logic [7:0] CMD_UNKNOWN_LO = 8'h01;
  localparam logic [7:0] ACT_OTHER      = 8'h5A;
  localparam logic [7:0] PRESENCE_UNUSED = 8'h00;

  typedef enum logic [1:0] {CFG_KEEP, CFG_CLEAR, CFG_SET} cfg_op_t;

  typedef struct packed {
    logic             late;
    cfg_op_t          op;
    crsr_pkg::req_t   req;
    logic             typed;
    crsr_pkg::rsp_t   reply;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_cmd = '0;
  logic [7:0] in_action = '0;
  logic [crsr_pkg::KEYS_W-1:0] in_keys = '0;
  logic in_card_present = 1'b0;
  logic [crsr_pkg::UID_W-1:0] in_card_uid = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [crsr_pkg::LEN_W-1:0] out_data_length;
  logic [7:0] out_reply_byte;
  logic [7:0] out_presence_code;
  logic [7:0] out_sensor_code;
  logic [7:0] out_keydown_code;
  logic [crsr_pkg::KEYS_W-1:0] out_keys_out;
  logic [crsr_pkg::UID_W-1:0] out_uid_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  // Predictor state, mirrors the block after reset.
  logic [crsr_pkg::KEYS_W-1:0] seen_keys = '0;
  logic [crsr_pkg::CNT_W-1:0] press_tag = crsr_pkg::CNT_BASE;
  logic accepting_card = 1'b0;
  logic holding_card = 1'b0;
  logic mode_is_new = 1'b0;
  logic ack_on_new_read = 1'b0;

  // Continuity of the random keypad and card slot.
  logic [crsr_pkg::KEYS_W-1:0] held_keys = '0;
  logic card_in_slot = 1'b0;

  crsr_pkg::rsp_t pending_replies[$];
  step_row_t plan [PLAN_ROWS];
  int fail_count = 0;
  int cycle_count = 0;
  int random_sent = 0;
  int stall_left = 0;
  logic squeeze_done = 1'b0;
  logic squeeze_req = 1'b0;
  logic calm = 1'b0;

  card_reader_status_responder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_action(in_action),
    .in_keys(in_keys),
    .in_card_present(in_card_present),
    .in_card_uid(in_card_uid),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data_length(out_data_length),
    .out_reply_byte(out_reply_byte),
    .out_presence_code(out_presence_code),
    .out_sensor_code(out_sensor_code),
    .out_keydown_code(out_keydown_code),
    .out_keys_out(out_keys_out),
    .out_uid_out(out_uid_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic crsr_pkg::rsp_t predict_reply(input crsr_pkg::req_t r);
    crsr_pkg::rsp_t o;
    logic [crsr_pkg::KEYS_W-1:0] fresh;
    logic [crsr_pkg::IDX_W-1:0] idx;
    logic found;
    o = '0;
    found = 1'b0;
    case (r.cmd)
      crsr_pkg::CMD_INIT_A, crsr_pkg::CMD_INIT_B, crsr_pkg::CMD_INIT_C,
      crsr_pkg::CMD_INIT_D, crsr_pkg::CMD_INIT_E: begin
        o.data_length = crsr_pkg::LEN_SHORT;
      end
      crsr_pkg::CMD_CARD_READ: begin
        o.data_length = crsr_pkg::LEN_FULL;
        o.reply_byte = crsr_pkg::REPLY_ACK;
        o.sensor_code = r.card_present ? crsr_pkg::SENSOR_FRONT : crsr_pkg::SENSOR_NONE;
      end
      crsr_pkg::CMD_STATUS, crsr_pkg::CMD_SET_ACTION: begin
        if (r.cmd == crsr_pkg::CMD_SET_ACTION) begin
          case (r.action)
            crsr_pkg::ACT_STOP: accepting_card = 1'b0;
            crsr_pkg::ACT_ACCEPT: accepting_card = 1'b1;
            crsr_pkg::ACT_EJECT: begin
              accepting_card = 1'b0;
              holding_card = 1'b0;
            end
            default: ;
          endcase
        end
        // Only the lowest newly pressed key is reported, but any press advances the tag.
        fresh = ~seen_keys & r.keys;
        for (int i = 0; i < crsr_pkg::KEY_COUNT_DEF; i++) begin
          if (!found && fresh[i]) begin
            idx = crsr_pkg::IDX_W'(i);
            o.keydown_code = {press_tag, idx};
            found = 1'b1;
          end
        end
        if (found) press_tag = (press_tag + 1'b1) | crsr_pkg::CNT_BASE;
        seen_keys = r.keys;
        o.data_length = crsr_pkg::LEN_FULL;
        o.reply_byte = crsr_pkg::REPLY_ZERO;
        o.keys_out = r.keys;
        o.uid_out = r.card_present ? r.card_uid : '0;
        if (mode_is_new) begin
          o.presence_code = r.card_present ? crsr_pkg::PRESENCE_CARD : crsr_pkg::PRESENCE_NONE;
          o.sensor_code = crsr_pkg::SENSOR_NONE;
        end else begin
          if (accepting_card && r.card_present) holding_card = 1'b1;
          if (holding_card) begin
            o.presence_code = crsr_pkg::PRESENCE_CARD;
            o.sensor_code = crsr_pkg::SENSOR_BOTH;
          end else if (r.card_present) begin
            o.presence_code = crsr_pkg::PRESENCE_CARD;
            o.sensor_code = crsr_pkg::SENSOR_FRONT;
          end else begin
            o.presence_code = crsr_pkg::PRESENCE_NONE;
            o.sensor_code = crsr_pkg::SENSOR_NONE;
          end
        end
      end
      crsr_pkg::CMD_NEW_READ: begin
        mode_is_new = 1'b1;
        if (ack_on_new_read) begin
          o.data_length = crsr_pkg::LEN_SHORT;
          o.reply_byte = crsr_pkg::REPLY_ACK;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic crsr_pkg::rsp_t plain_reply(input logic [crsr_pkg::LEN_W-1:0] len,
                                                 input logic [7:0] first,
                                                 input logic [7:0] presence,
                                                 input logic [7:0] sensor);
    crsr_pkg::rsp_t o;
    o = '0;
    o.data_length = len;
    o.reply_byte = first;
    o.presence_code = presence;
    o.sensor_code = sensor;
    return o;
  endfunction

  function automatic step_row_t mk(input logic late, input cfg_op_t op, input logic [7:0] cmd,
                                   input logic [7:0] action,
                                   input logic [crsr_pkg::KEYS_W-1:0] keys,
                                   input logic card, input logic [crsr_pkg::UID_W-1:0] uid,
                                   input logic typed, input crsr_pkg::rsp_t reply);
    step_row_t s;
    s.late = late;
    s.op = op;
    s.req.cmd = cmd;
    s.req.action = action;
    s.req.keys = keys;
    s.req.card_present = card;
    s.req.card_uid = uid;
    s.typed = typed;
    s.reply = reply;
    return s;
  endfunction

  // Mostly protocol commands with a keypad that changes a key at a time and a card that
  // stays put for a while; the rest is arbitrary command bytes.
  function automatic crsr_pkg::req_t random_request(input logic allow_new_read);
    crsr_pkg::req_t r;
    int pick;
    logic [crsr_pkg::KEYS_W-1:0] one_key;
    pick = $urandom_range(99);
    if (pick < 38) r.cmd = crsr_pkg::CMD_STATUS;
    else if (pick < 60) r.cmd = crsr_pkg::CMD_SET_ACTION;
    else if (pick < 68) r.cmd = crsr_pkg::CMD_CARD_READ;
    else if (pick < 76) begin
      case ($urandom_range(4))
        0: r.cmd = crsr_pkg::CMD_INIT_A;
        1: r.cmd = crsr_pkg::CMD_INIT_B;
        2: r.cmd = crsr_pkg::CMD_INIT_C;
        3: r.cmd = crsr_pkg::CMD_INIT_D;
        default: r.cmd = crsr_pkg::CMD_INIT_E;
      endcase
    end else if (pick < 80 && allow_new_read) r.cmd = crsr_pkg::CMD_NEW_READ;
    else begin
      r.cmd = 8'($urandom_range(255));
      if (!allow_new_read && r.cmd == crsr_pkg::CMD_NEW_READ) r.cmd = crsr_pkg::CMD_STATUS;
    end
    pick = $urandom_range(9);
    if (pick < 3) r.action = crsr_pkg::ACT_ACCEPT;
    else if (pick < 5) r.action = crsr_pkg::ACT_STOP;
    else if (pick < 7) r.action = crsr_pkg::ACT_EJECT;
    else r.action = 8'($urandom_range(255));
    pick = $urandom_range(9);
    if (pick >= 8) held_keys = crsr_pkg::KEYS_W'($urandom_range(4095));
    else if (pick >= 4) begin
      one_key = crsr_pkg::KEYS_W'(1);
      one_key = one_key << $urandom_range(crsr_pkg::KEYS_W - 1);
      held_keys = held_keys ^ one_key;
    end
    r.keys = held_keys;
    if ($urandom_range(99) < 15) card_in_slot = ~card_in_slot;
    r.card_present = card_in_slot;
    pick = $urandom_range(19);
    if (pick == 0) r.card_uid = '0;
    else if (pick == 1) r.card_uid = '1;
    else r.card_uid = {$urandom, $urandom};
    return r;
  endfunction

  task automatic push_request(input crsr_pkg::req_t r, input logic typed,
                              input crsr_pkg::rsp_t typed_reply);
    int gap;
    crsr_pkg::rsp_t predicted;
    gap = 0;
    while (!calm && $urandom_range(99) < 17) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= r.cmd;
    in_action <= r.action;
    in_keys <= r.keys;
    in_card_present <= r.card_present;
    in_card_uid <= r.card_uid;
    do @(posedge clk); while (!in_ready);
    predicted = predict_reply(r);
    pending_replies.push_back(typed ? typed_reply : predicted);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_reply_ack(input logic value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    ack_on_new_read = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_plan(input logic late_rows);
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].late == late_rows) begin
        if (plan[i].op != CFG_KEEP) begin
          drain();
          write_reply_ack(plan[i].op == CFG_SET);
        end
        push_request(plan[i].req, plan[i].typed, plan[i].reply);
      end
    end
  endtask

  task automatic run_random(input int count, input logic allow_new_read);
    crsr_pkg::req_t r;
    for (int n = 0; n < count; n++) begin
      random_sent++;
      if (random_sent == 60) squeeze_req <= 1'b1;
      calm <= (random_sent >= 200 && random_sent < 320);
      r = random_request(allow_new_read);
      push_request(r, 1'b0, '0);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : reply_check
    crsr_pkg::rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        $error("reply beat with no request outstanding");
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        check_field("data_length", want.data_length, out_data_length);
        check_field("reply_byte", want.reply_byte, out_reply_byte);
        check_field("presence_code", want.presence_code, out_presence_code);
        check_field("sensor_code", want.sensor_code, out_sensor_code);
        check_field("keydown_code", want.keydown_code, out_keydown_code);
        check_field("keys_out", want.keys_out, out_keys_out);
        check_field("uid_out", want.uid_out, out_uid_out);
      end
    end
    // One long hold-off lets the block fill up while requests keep coming.
    if (squeeze_req && !squeeze_done) begin
      stall_left = SQUEEZE_CYCLES;
      squeeze_done = 1'b1;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && (calm || $urandom_range(99) >= 17);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    // Old slotted mode first, since the new-reader read switches modes for good.
    plan[0]  = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_STATUS, crsr_pkg::ACT_STOP, 12'h000, 1'b0, '0,
                  1'b1, plain_reply(crsr_pkg::LEN_FULL, crsr_pkg::REPLY_ZERO,
                                    crsr_pkg::PRESENCE_NONE, crsr_pkg::SENSOR_NONE));
    plan[1]  = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_INIT_A, 8'hFF, 12'hFFF, 1'b1, '1,
                  1'b1, plain_reply(crsr_pkg::LEN_SHORT, crsr_pkg::REPLY_ZERO,
                                    PRESENCE_UNUSED, crsr_pkg::SENSOR_NONE));
    plan[2]  = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_INIT_B, crsr_pkg::ACT_ACCEPT, 12'hA5A, 1'b1,
                  64'h0123_4567_89AB_CDEF,
                  1'b1, plain_reply(crsr_pkg::LEN_SHORT, crsr_pkg::REPLY_ZERO,
                                    PRESENCE_UNUSED, crsr_pkg::SENSOR_NONE));
    plan[3]  = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_INIT_C, crsr_pkg::ACT_EJECT, 12'h000, 1'b0, '0,
                  1'b1, plain_reply(crsr_pkg::LEN_SHORT, crsr_pkg::REPLY_ZERO,
                                    PRESENCE_UNUSED, crsr_pkg::SENSOR_NONE));
    plan[4]  = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_INIT_D, crsr_pkg::ACT_STOP, 12'h5A5, 1'b1, '1,
                  1'b1, plain_reply(crsr_pkg::LEN_SHORT, crsr_pkg::REPLY_ZERO,
                                    PRESENCE_UNUSED, crsr_pkg::SENSOR_NONE));
    plan[5]  = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_INIT_E, 8'hFF, 12'hFFF, 1'b0, '1,
                  1'b1, plain_reply(crsr_pkg::LEN_SHORT, crsr_pkg::REPLY_ZERO,
                                    PRESENCE_UNUSED, crsr_pkg::SENSOR_NONE));
    plan[6]  = mk(1'b0, CFG_KEEP, CMD_UNKNOWN_HI, 8'hFF, 12'hFFF, 1'b1, '1,
                  1'b1, plain_reply(crsr_pkg::LEN_NONE, crsr_pkg::REPLY_ZERO,
                                    PRESENCE_UNUSED, crsr_pkg::SENSOR_NONE));
    plan[7]  = mk(1'b0, CFG_KEEP, CMD_UNKNOWN_LO, crsr_pkg::ACT_ACCEPT, 12'hFFF, 1'b1, '1,
                  1'b1, plain_reply(crsr_pkg::LEN_NONE, crsr_pkg::REPLY_ZERO,
                                    PRESENCE_UNUSED, crsr_pkg::SENSOR_NONE));
    plan[8]  = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_CARD_READ, 8'hFF, 12'hFFF, 1'b1, '1,
                  1'b1, plain_reply(crsr_pkg::LEN_FULL, crsr_pkg::REPLY_ACK,
                                    PRESENCE_UNUSED, crsr_pkg::SENSOR_FRONT));
    plan[9]  = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_CARD_READ, crsr_pkg::ACT_STOP, 12'h000, 1'b0,
                  '1,
                  1'b1, plain_reply(crsr_pkg::LEN_FULL, crsr_pkg::REPLY_ACK,
                                    PRESENCE_UNUSED, crsr_pkg::SENSOR_NONE));
    plan[10] = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_STATUS, crsr_pkg::ACT_STOP, 12'hFFF, 1'b1, '1,
                  1'b0, '0);
    plan[11] = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_STATUS, crsr_pkg::ACT_STOP, 12'hFFF, 1'b1, '0,
                  1'b0, '0);
    plan[12] = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_STATUS, crsr_pkg::ACT_STOP, 12'h000, 1'b0, '1,
                  1'b0, '0);
    plan[13] = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_STATUS, crsr_pkg::ACT_STOP, 12'h800, 1'b1,
                  64'hFEDC_BA98_7654_3210, 1'b0, '0);
    plan[14] = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_STATUS, crsr_pkg::ACT_STOP, 12'h555, 1'b0, '1,
                  1'b0, '0);
    plan[15] = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_STATUS, crsr_pkg::ACT_STOP, 12'hAAA, 1'b0, '1,
                  1'b0, '0);
    // Accept, then a card arriving makes the block hold it until an eject.
    plan[16] = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_SET_ACTION, crsr_pkg::ACT_ACCEPT, 12'h555, 1'b0,
                  '1, 1'b0, '0);
    plan[17] = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_STATUS, crsr_pkg::ACT_STOP, 12'h000, 1'b1,
                  64'h8000_0000_0000_0001, 1'b0, '0);
    plan[18] = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_SET_ACTION, crsr_pkg::ACT_STOP, 12'h001, 1'b0,
                  '1, 1'b0, '0);
    plan[19] = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_SET_ACTION, ACT_OTHER, 12'h003, 1'b0,
                  '1, 1'b0, '0);
    plan[20] = mk(1'b0, CFG_KEEP, crsr_pkg::CMD_SET_ACTION, crsr_pkg::ACT_EJECT, 12'h007, 1'b1,
                  '1, 1'b0, '0);
    plan[21] = mk(1'b1, CFG_CLEAR, crsr_pkg::CMD_NEW_READ, 8'hFF, 12'hFFF, 1'b1, '1,
                  1'b1, plain_reply(crsr_pkg::LEN_NONE, crsr_pkg::REPLY_ZERO,
                                    PRESENCE_UNUSED, crsr_pkg::SENSOR_NONE));
    plan[22] = mk(1'b1, CFG_SET, crsr_pkg::CMD_NEW_READ, crsr_pkg::ACT_STOP, 12'h000, 1'b0, '0,
                  1'b1, plain_reply(crsr_pkg::LEN_SHORT, crsr_pkg::REPLY_ACK,
                                    PRESENCE_UNUSED, crsr_pkg::SENSOR_NONE));
    plan[23] = mk(1'b1, CFG_KEEP, crsr_pkg::CMD_STATUS, crsr_pkg::ACT_STOP, 12'hFFF, 1'b1, '1,
                  1'b0, '0);
    plan[24] = mk(1'b1, CFG_KEEP, crsr_pkg::CMD_SET_ACTION, crsr_pkg::ACT_ACCEPT, 12'h000, 1'b1,
                  '1, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    write_reply_ack(1'b0);
    run_plan(1'b0);
    run_random(500, 1'b0);
    run_plan(1'b1);
    run_random(350, 1'b1);
    drain();
    write_reply_ack(1'b0);
    run_random(350, 1'b1);
    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
